>>> hw/rtl/ssmt_pkg.sv
// ----------------------------------------------------------------------------
// ssmt_pkg
// Shared types and constants of the slot store with match-and-take.
// ----------------------------------------------------------------------------
`default_nettype none

package ssmt_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int CMD_W       = 2;
    localparam int TXN_W       = 16;
    localparam int SRC_W       = 8;
    localparam int PAY_W       = 32;
    localparam int KEY_W       = 16;
    localparam int ENTRY_W     = TXN_W + SRC_W + PAY_W;

    localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TAKE_SRC = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TAKE_TXN = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

>>> hw/rtl/ssmt_ctrl.sv
// ----------------------------------------------------------------------------
// ssmt_ctrl
// Sequencer: accepts a beat, steps the slot scan, hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmt_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  ssmt_pkg::t_dp_status  i_status,
    output ssmt_pkg::t_dp_cmd     o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/ssmt_datapath.sv
// ----------------------------------------------------------------------------
// ssmt_datapath
// Slot memory, valid marks, scan index, compare and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmt_datapath #(
    parameter int SLOTS = ssmt_pkg::SLOTS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  ssmt_pkg::t_dp_cmd                  i_cmd,
    output ssmt_pkg::t_dp_status               o_status,
    input  wire [ssmt_pkg::CMD_W-1:0]          i_cmd_code,
    input  wire [ssmt_pkg::TXN_W-1:0]          i_in_txn_id,
    input  wire [ssmt_pkg::SRC_W-1:0]          i_in_source,
    input  wire [ssmt_pkg::PAY_W-1:0]          i_in_payload,
    input  wire [ssmt_pkg::KEY_W-1:0]          i_match_key,
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic                               o_status_bit,
    output logic [ssmt_pkg::TXN_W-1:0]         o_out_txn_id,
    output logic [ssmt_pkg::SRC_W-1:0]         o_out_source,
    output logic [ssmt_pkg::PAY_W-1:0]         o_out_payload
);

    localparam int IW = $clog2(SLOTS);
    localparam int EW = ssmt_pkg::ENTRY_W;
    localparam int PW = ssmt_pkg::PAY_W;
    localparam int SW = ssmt_pkg::SRC_W;
    localparam int TW = ssmt_pkg::TXN_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    logic [EW-1:0]               r_mem [SLOTS];
    logic [SLOTS-1:0]            r_valid;

    logic [ssmt_pkg::CMD_W-1:0]  r_cmd;
    logic [EW-1:0]               r_wr_entry;
    logic [ssmt_pkg::KEY_W-1:0]  r_key;

    logic [IW-1:0]               r_idx;
    logic                        r_issue;
    logic [IW-1:0]               r_rd_idx;
    logic                        r_rd_vld;
    logic [EW-1:0]               r_rd_data;

    logic                        r_hit;
    logic [EW-1:0]               r_hit_data;

    logic                        w_is_write;
    logic                        w_is_take;
    logic                        w_free;
    logic                        w_wr_hit;
    logic                        w_match;
    logic                        w_tk_hit;
    logic                        w_done;

    assign w_is_write = (r_cmd == ssmt_pkg::CMD_WRITE);
    assign w_is_take  = (r_cmd == ssmt_pkg::CMD_TAKE_SRC) ||
                        (r_cmd == ssmt_pkg::CMD_TAKE_TXN);
    assign w_free     = !r_valid[r_idx];
    assign w_wr_hit   = w_is_write && w_free;

    always_comb begin
        if (r_cmd == ssmt_pkg::CMD_TAKE_SRC) begin
            w_match = ({{(ssmt_pkg::KEY_W - SW){1'b0}}, r_rd_data[PW +: SW]} == r_key);
        end else begin
            w_match = (r_rd_data[PW + SW +: TW] == r_key);
        end
    end

    assign w_tk_hit = w_is_take && r_rd_vld && r_valid[r_rd_idx] && w_match;

    always_comb begin
        if (w_is_write) begin
            w_done = w_free || (r_idx == LAST_IDX);
        end else if (w_is_take) begin
            w_done = w_tk_hit || (r_rd_vld && (r_rd_idx == LAST_IDX));
        end else begin
            w_done = 1'b1;
        end
    end

    assign o_status.scan_done = w_done;
    assign o_status.out_free  = !o_out_valid || !i_out_stall;

    // slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_wr_hit) begin
            r_mem[r_idx] <= r_wr_entry;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.step && w_wr_hit) begin
            r_valid[r_idx] <= 1'b1;
        end else if (i_cmd.step && w_tk_hit) begin
            r_valid[r_rd_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd      <= i_cmd_code;
            r_wr_entry <= {i_in_txn_id, i_in_source, i_in_payload};
            r_key      <= i_match_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_issue    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_rd_idx   <= '0;
            r_hit      <= 1'b0;
            r_hit_data <= '0;
        end else if (i_cmd.load) begin
            r_idx      <= '0;
            r_issue    <= 1'b1;
            r_rd_vld   <= 1'b0;
            r_hit      <= 1'b0;
            r_hit_data <= '0;
        end else if (i_cmd.step) begin
            r_rd_vld <= r_issue;
            r_rd_idx <= r_idx;
            if (r_idx == LAST_IDX) begin
                r_issue <= 1'b0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_wr_hit) begin
                r_hit <= 1'b1;
            end
            if (w_tk_hit) begin
                r_hit      <= 1'b1;
                r_hit_data <= r_rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_status_bit  <= !r_hit;
            o_out_txn_id  <= r_hit_data[PW + SW +: TW];
            o_out_source  <= r_hit_data[PW +: SW];
            o_out_payload <= r_hit_data[PW-1:0];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/slot_store_match_take_top.sv
// ----------------------------------------------------------------------------
// slot_store_match_take_top
// Associative slot store: write to first free slot, take by source or id.
//
// Input channel (i_in_valid / o_in_stall) carries one command beat: write,
// take by source id, or take by transaction id. Output channel
// (o_out_valid / i_out_stall) returns exactly one result beat per command.
// Slots are scanned one per cycle from slot 0; the memory read port and the
// single compare set the pace. A write that lands in slot k or a take that
// hits slot k gives its result later the higher k is; a full store or a miss
// scans every slot, and an unused command ends the scan at once. The next beat
// is accepted the cycle after the result is loaded, one command at a time.
// The result sits in an output register; while the receiver stalls it holds,
// a new command is still accepted and scanned, and its result waits until
// the register frees.
// Reset clears all valid marks at once and empties the output register;
// slot contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_store_match_take_top #(
    parameter int SLOTS = ssmt_pkg::SLOTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire [ssmt_pkg::CMD_W-1:0]    i_cmd,
    input  wire [ssmt_pkg::TXN_W-1:0]    i_in_txn_id,
    input  wire [ssmt_pkg::SRC_W-1:0]    i_in_source,
    input  wire [ssmt_pkg::PAY_W-1:0]    i_in_payload,
    input  wire [ssmt_pkg::KEY_W-1:0]    i_match_key,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic                         o_status,
    output logic [ssmt_pkg::TXN_W-1:0]   o_out_txn_id,
    output logic [ssmt_pkg::SRC_W-1:0]   o_out_source,
    output logic [ssmt_pkg::PAY_W-1:0]   o_out_payload
);

    ssmt_pkg::t_dp_cmd    w_cmd;
    ssmt_pkg::t_dp_status w_status;

    ssmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ssmt_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cmd_code    (i_cmd),
        .i_in_txn_id   (i_in_txn_id),
        .i_in_source   (i_in_source),
        .i_in_payload  (i_in_payload),
        .i_match_key   (i_match_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status_bit  (o_status),
        .o_out_txn_id  (o_out_txn_id),
        .o_out_source  (o_out_source),
        .o_out_payload (o_out_payload)
    );

endmodule

`default_nettype wire

>>> tb/sv/ssmt_checker.sv
// ----------------------------------------------------------------------------
// ssmt_checker
// Watches both channels of the slot store. Every accepted command beat is run
// through a local copy of the slot store and its result is queued; every
// accepted result beat is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssmt_checker #(
    parameter int SLOTS = ssmt_pkg::SLOTS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire                          i_in_stall,
    input  wire [ssmt_pkg::CMD_W-1:0]    i_cmd,
    input  wire [ssmt_pkg::TXN_W-1:0]    i_in_txn_id,
    input  wire [ssmt_pkg::SRC_W-1:0]    i_in_source,
    input  wire [ssmt_pkg::PAY_W-1:0]    i_in_payload,
    input  wire [ssmt_pkg::KEY_W-1:0]    i_match_key,
    input  wire                          i_out_valid,
    input  wire                          i_out_stall,
    input  wire                          i_status,
    input  wire [ssmt_pkg::TXN_W-1:0]    i_out_txn_id,
    input  wire [ssmt_pkg::SRC_W-1:0]    i_out_source,
    input  wire [ssmt_pkg::PAY_W-1:0]    i_out_payload,
    output int                           o_mismatches,
    output int                           o_pending,
    output int                           o_hits,
    output int                           o_misses,
    output int                           o_drops
);

    localparam int CMD_W = ssmt_pkg::CMD_W;
    localparam int TXN_W = ssmt_pkg::TXN_W;
    localparam int SRC_W = ssmt_pkg::SRC_W;
    localparam int PAY_W = ssmt_pkg::PAY_W;
    localparam int KEY_W = ssmt_pkg::KEY_W;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic             status;
        logic [TXN_W-1:0] txn_id;
        logic [SRC_W-1:0] source;
        logic [PAY_W-1:0] payload;
    } t_take_result;

    logic             slot_used [SLOTS];
    logic [TXN_W-1:0] slot_txn  [SLOTS];
    logic [SRC_W-1:0] slot_src  [SLOTS];
    logic [PAY_W-1:0] slot_pay  [SLOTS];

    t_take_result expected_results [$];

    int mismatch_count = 0;
    int hit_count      = 0;
    int miss_count     = 0;
    int drop_count     = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_hits       = 0;
        o_misses     = 0;
        o_drops      = 0;
    end

    task automatic report_mismatch(input string what, input logic [PAY_W-1:0] seen,
                                   input logic [PAY_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("%0t ns: result mismatch on %s: got %0h, want %0h",
                     $time, what, seen, want);
        end
    endtask

    // Slot store behavior: first free slot on write, lowest matching valid
    // slot on take; anything else answers with status 1 and zero data.
    task automatic predict_take_result(input logic [CMD_W-1:0] cmd,
                                       input logic [TXN_W-1:0] txn,
                                       input logic [SRC_W-1:0] src,
                                       input logic [PAY_W-1:0] pay,
                                       input logic [KEY_W-1:0] key);
        t_take_result res;
        logic         found;
        logic         hit;
        res        = '0;
        res.status = 1'b1;
        found      = 1'b0;
        case (cmd)
            ssmt_pkg::CMD_WRITE: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && !slot_used[i]) begin
                        slot_used[i] = 1'b1;
                        slot_txn[i]  = txn;
                        slot_src[i]  = src;
                        slot_pay[i]  = pay;
                        found        = 1'b1;
                        res.status   = 1'b0;
                    end
                end
                if (!found) drop_count++;
            end
            ssmt_pkg::CMD_TAKE_SRC, ssmt_pkg::CMD_TAKE_TXN: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (cmd == ssmt_pkg::CMD_TAKE_SRC) begin
                        hit = ({{(KEY_W-SRC_W){1'b0}}, slot_src[i]} == key);
                    end else begin
                        hit = (slot_txn[i] == key);
                    end
                    if (!found && slot_used[i] && hit) begin
                        slot_used[i] = 1'b0;
                        res.status   = 1'b0;
                        res.txn_id   = slot_txn[i];
                        res.source   = slot_src[i];
                        res.payload  = slot_pay[i];
                        found        = 1'b1;
                    end
                end
                if (found) hit_count++;
                else miss_count++;
            end
            default: ;
        endcase
        expected_results.push_back(res);
    endtask

    always @(posedge i_clk) begin : watch
        t_take_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("beat with nothing expected", '0, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status)
                        report_mismatch("status", PAY_W'(i_status), PAY_W'(want.status));
                    if (i_out_txn_id !== want.txn_id)
                        report_mismatch("txn_id", PAY_W'(i_out_txn_id),
                                        PAY_W'(want.txn_id));
                    if (i_out_source !== want.source)
                        report_mismatch("source", PAY_W'(i_out_source),
                                        PAY_W'(want.source));
                    if (i_out_payload !== want.payload)
                        report_mismatch("payload", i_out_payload, want.payload);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_take_result(i_cmd, i_in_txn_id, i_in_source, i_in_payload,
                                    i_match_key);
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= expected_results.size();
        o_hits       <= hit_count;
        o_misses     <= miss_count;
        o_drops      <= drop_count;
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_slot_store_match_take_top.sv
// ----------------------------------------------------------------------------
// tb_slot_store_match_take_top
// Drives the slot store with a short directed sequence (empty store, fill to
// full, dropped write, wide source key, duplicate keys, unused command) and
// then phases of random commands with varying write mix and random idling on
// both channels, including one long output hold-off. The checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_slot_store_match_take_top;

    localparam int CMD_W     = ssmt_pkg::CMD_W;
    localparam int TXN_W     = ssmt_pkg::TXN_W;
    localparam int SRC_W     = ssmt_pkg::SRC_W;
    localparam int PAY_W     = ssmt_pkg::PAY_W;
    localparam int KEY_W     = ssmt_pkg::KEY_W;
    localparam int SLOTS_DEF = ssmt_pkg::SLOTS_DEF;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_BEATS = 1600;
    localparam int PHASE_BEATS  = 200;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [CMD_W-1:0]   i_cmd;
    logic [TXN_W-1:0]   i_in_txn_id;
    logic [SRC_W-1:0]   i_in_source;
    logic [PAY_W-1:0]   i_in_payload;
    logic [KEY_W-1:0]   i_match_key;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_status;
    logic [TXN_W-1:0]   o_out_txn_id;
    logic [SRC_W-1:0]   o_out_source;
    logic [PAY_W-1:0]   o_out_payload;

    int mismatches;
    int pending;
    int hits;
    int misses;
    int drops;

    int   cycle_count = 0;
    logic tx_gaps_on  = 1'b0;
    logic rx_gaps_on;
    logic hold_go;
    logic hold_out;
    int   writes_sent = 0;
    int   takes_sent  = 0;
    int   unused_sent = 0;

    slot_store_match_take_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_in_txn_id   (i_in_txn_id),
        .i_in_source   (i_in_source),
        .i_in_payload  (i_in_payload),
        .i_match_key   (i_match_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_out_txn_id  (o_out_txn_id),
        .o_out_source  (o_out_source),
        .o_out_payload (o_out_payload)
    );

    ssmt_checker #(
        .SLOTS (SLOTS_DEF)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_in_txn_id   (i_in_txn_id),
        .i_in_source   (i_in_source),
        .i_in_payload  (i_in_payload),
        .i_match_key   (i_match_key),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_status      (o_status),
        .i_out_txn_id  (o_out_txn_id),
        .i_out_source  (o_out_source),
        .i_out_payload (o_out_payload),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_hits        (hits),
        .o_misses      (misses),
        .o_drops       (drops)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly small key pools so takes hit often; now and then the top of
    // the range or a fully random value.
    function automatic logic [TXN_W-1:0] pick_txn();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return TXN_W'($urandom_range(0, 7));
        if (r == 7) return TXN_W'(16'hFFFF - $urandom_range(0, 3));
        return TXN_W'($urandom());
    endfunction

    function automatic logic [SRC_W-1:0] pick_src();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return SRC_W'($urandom_range(0, 7));
        if (r == 7) return SRC_W'(8'hFF - $urandom_range(0, 3));
        return SRC_W'($urandom());
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(input logic [CMD_W-1:0] cmd);
        if (cmd == ssmt_pkg::CMD_TAKE_SRC) begin
            if ($urandom_range(0, 9) < 8) return {{(KEY_W-SRC_W){1'b0}}, pick_src()};
            return KEY_W'($urandom());
        end
        return pick_txn();
    endfunction

    // Starts and ends at a rising edge; returns on the edge the beat is taken.
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [TXN_W-1:0] txn,
                             input logic [SRC_W-1:0] src, input logic [PAY_W-1:0] pay,
                             input logic [KEY_W-1:0] key);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_in_txn_id  <= txn;
        i_in_source  <= src;
        i_in_payload <= pay;
        i_match_key  <= key;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        case (cmd)
            ssmt_pkg::CMD_WRITE:                            writes_sent++;
            ssmt_pkg::CMD_TAKE_SRC, ssmt_pkg::CMD_TAKE_TXN: takes_sent++;
            default:                                        unused_sent++;
        endcase
    endtask

    initial begin : hold_off
        hold_out <= 1'b0;
        wait (hold_go === 1'b1);
        @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    initial begin : receiver
        int   stall_left;
        logic next_stall;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                stall_left = (rx_gaps_on === 1'b1) ? $urandom_range(0, 4) : 0;
            end
            next_stall = hold_out;
            if (!hold_out && stall_left > 0) begin
                stall_left--;
                next_stall = 1'b1;
            end
            i_out_stall <= next_stall;
        end
    end

    initial begin : stimulus
        int               write_pct;
        int               r;
        logic [CMD_W-1:0] cmd;

        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_cmd        <= ssmt_pkg::CMD_WRITE;
        i_in_txn_id  <= '0;
        i_in_source  <= '0;
        i_in_payload <= '0;
        i_match_key  <= '0;
        rx_gaps_on   <= 1'b0;
        hold_go      <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty store, fill, full, wide key, duplicates, reuse
        send_beat(CMD_UNUSED, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(ssmt_pkg::CMD_TAKE_SRC, '0, '0, '0, 16'h0000);
        send_beat(ssmt_pkg::CMD_TAKE_TXN, '0, '0, '0, 16'h0000);
        send_beat(ssmt_pkg::CMD_WRITE, 16'h0000, 8'h00, 32'h0000_0000, 16'hFFFF);
        send_beat(ssmt_pkg::CMD_WRITE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 16'h0000);
        for (int i = 2; i < SLOTS_DEF; i++) begin
            send_beat(ssmt_pkg::CMD_WRITE, TXN_W'(16'h1000 + i), SRC_W'(i % 4),
                      $urandom(), '0);
        end
        send_beat(ssmt_pkg::CMD_WRITE, 16'hBEEF, 8'h5A, 32'h1234_5678, '0);
        send_beat(ssmt_pkg::CMD_TAKE_SRC, '0, '0, '0, 16'h01FF);
        send_beat(ssmt_pkg::CMD_TAKE_SRC, '0, '0, '0, 16'h00FF);
        send_beat(ssmt_pkg::CMD_TAKE_TXN, '0, '0, '0, 16'h0000);
        send_beat(ssmt_pkg::CMD_WRITE, 16'h7777, 8'h80, 32'h8000_0001, '0);
        send_beat(ssmt_pkg::CMD_TAKE_SRC, '0, '0, '0, 16'h0003);

        for (int ph = 0; ph < RANDOM_BEATS / PHASE_BEATS; ph++) begin
            write_pct  = (ph == 0) ? 85 : (ph == 1) ? 12 : $urandom_range(15, 85);
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on <= ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (ph == 2 && n == 50) hold_go <= 1'b1;
                r = $urandom_range(0, 99);
                if (r < 4) cmd = CMD_UNUSED;
                else if (r < 4 + write_pct) cmd = ssmt_pkg::CMD_WRITE;
                else if ($urandom_range(0, 1) == 0) cmd = ssmt_pkg::CMD_TAKE_SRC;
                else cmd = ssmt_pkg::CMD_TAKE_TXN;
                send_beat(cmd, pick_txn(), pick_src(), $urandom(), pick_key(cmd));
            end
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d writes, %0d takes and %0d unused commands in %0d cycles.",
                 writes_sent, takes_sent, unused_sent, cycle_count);
        $display("Takes found %0d entries and missed %0d; %0d writes hit a full store.",
                 hits, misses, drops);
        if (mismatches == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/ssmt_pkg.sv
hw/rtl/ssmt_ctrl.sv
hw/rtl/ssmt_datapath.sv
hw/rtl/slot_store_match_take_top.sv
tb/sv/ssmt_checker.sv
tb/sv/tb_slot_store_match_take_top.sv
